@@ hdl/iste_pkg.sv @@
// Shared types, constants and the month table for the timestamp-to-epoch block.
// No dependencies; used by iste_parse, iste_calc and iso_timestamp_to_epoch.
`default_nettype none

package iste_pkg;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Layout of "YYYY-MM-DDTHH:MM:SS+HH:MM": first position of each field
  localparam int unsigned POS_W = 5;
  localparam logic [POS_W-1:0] POS_YEAR   = 5'd0;
  localparam logic [POS_W-1:0] POS_YEAR_END = 5'd3;
  localparam logic [POS_W-1:0] POS_MONTH  = 5'd5;
  localparam logic [POS_W-1:0] POS_DAY    = 5'd8;
  localparam logic [POS_W-1:0] POS_HOUR   = 5'd11;
  localparam logic [POS_W-1:0] POS_MINUTE = 5'd14;
  localparam logic [POS_W-1:0] POS_SECOND = 5'd17;
  localparam logic [POS_W-1:0] POS_SIGN   = 5'd19;
  localparam logic [POS_W-1:0] POS_ZHOUR  = 5'd20;
  localparam logic [POS_W-1:0] POS_ZMIN   = 5'd23;
  localparam logic [POS_W-1:0] LAST_POS   = 5'd24;

  // Field widths
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned FLD_W  = 7;
  localparam int unsigned DAYS_W = 13;  // signed day count, -1 .. 4095
  localparam int unsigned Q_W    = 8;   // year / 100 for a 14-bit year

  // Calendar and time constants
  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1970;
  localparam logic [YEAR_W-1:0] LEAP_BASE_YEAR = 14'd1972;
  localparam logic [YEAR_W-1:0] CENTURY = 14'd100;
  localparam logic [DAYS_W-1:0] LEAP_Q4_BASE   = 13'd492;  // 1971 / 4
  localparam logic [DAYS_W-1:0] LEAP_Q100_BASE = 13'd19;   // 1971 / 100
  localparam logic [DAYS_W-1:0] LEAP_Q400_BASE = 13'd4;    // 1971 / 400
  localparam logic [31:0] SECS_PER_YEAR = 32'd31536000;
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [19:0] SECS_PER_HOUR = 20'd3600;
  localparam logic [19:0] SECS_PER_MIN  = 20'd60;

  // floor(n / 100) = (n * 5243) >> 19 for every n below 43699
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  // Parsed digit fields after the current character
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [FLD_W-1:0]  month;
    logic [FLD_W-1:0]  day;
    logic [FLD_W-1:0]  hour;
    logic [FLD_W-1:0]  minute;
    logic [FLD_W-1:0]  second;
    logic              zone_neg;
    logic [FLD_W-1:0]  zone_hours;
    logic [FLD_W-1:0]  zone_minutes;
    logic              err;
  } fields_t;

  // Days in the months before month m (1..12); other codes give zero
  function automatic logic [8:0] days_before_month(logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ hdl/iso_timestamp_to_epoch.sv @@
// Top level: timestamp character parser, epoch arithmetic pipeline, result register.
// Depends on iste_pkg, iste_parse and iste_calc.
`default_nettype none

// Takes the text "YYYY-MM-DDTHH:MM:SS+HH:MM" one character per transfer, at up to
// one character per clock, and after the 25th character delivers seconds since
// 1970 plus the zone offset, with a format error flag. in_start_req marks the
// first character and drops any partial timestamp; after the last character the
// position wraps to zero by itself. After the last character the result moves
// through the calc stages to the output register. Characters keep flowing while a
// result waits on the output; only the last character of the next timestamp is
// held off until the previous result has left the pipeline and the output
// register, so a stalled consumer stalls the input at most at that one character.
module iso_timestamp_to_epoch (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_ch,
  input  logic               in_start_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_epoch_seconds,
  output logic               out_format_error
);

  logic [iste_pkg::POS_W-1:0] pos;
  iste_pkg::fields_t          fields_nxt;
  logic                       in_xfer;
  logic                       at_last;
  logic                       launch;
  logic [3:0]                 stage_valid;
  logic                       res_valid;
  logic [31:0]                res_epoch;
  logic                       res_err;

  logic                       out_valid_r;
  logic [31:0]                out_epoch_r;
  logic                       out_err_r;

  assign at_last  = (pos == iste_pkg::LAST_POS);
  // Hold the last character while a result is still in flight
  assign in_ready = !(at_last && ((|stage_valid) || out_valid_r));
  assign in_xfer  = in_valid && in_ready;
  assign launch   = in_xfer && !in_start_req && at_last;

  iste_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .xfer       (in_xfer),
    .ch         (in_ch),
    .start_req  (in_start_req),
    .pos_o      (pos),
    .fields_nxt (fields_nxt)
  );

  iste_calc u_calc (
    .clk         (clk),
    .rst_n       (rst_n),
    .launch      (launch),
    .fields      (fields_nxt),
    .stage_valid (stage_valid),
    .res_valid   (res_valid),
    .res_epoch   (res_epoch),
    .res_err     (res_err)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_epoch_r <= res_epoch;
      out_err_r   <= res_err;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_epoch_seconds = $signed(out_epoch_r);
  assign out_format_error  = out_err_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !out_valid_r)
    else $error("result arrived while the output register was full");

  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({stage_valid, out_valid_r}))
    else $error("more than one result in flight");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    launch |-> ##4 res_valid)
    else $error("pipeline latency broken");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos <= iste_pkg::LAST_POS)
    else $error("character position out of range");
`endif

endmodule

`default_nettype wire

@@ hdl/iste_parse.sv @@
// Character position counter and digit field capture for the timestamp text.
// Depends on iste_pkg (layout positions, character codes, fields_t).
`default_nettype none

module iste_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          xfer,
  input  logic [7:0]                    ch,
  input  logic                          start_req,
  output logic [iste_pkg::POS_W-1:0]    pos_o,
  output iste_pkg::fields_t             fields_nxt
);

  typedef enum logic [3:0] {
    FLD_NONE,
    FLD_YEAR,
    FLD_MONTH,
    FLD_DAY,
    FLD_HOUR,
    FLD_MINUTE,
    FLD_SECOND,
    FLD_SIGN,
    FLD_ZHOUR,
    FLD_ZMIN
  } field_sel_t;

  logic [iste_pkg::POS_W-1:0] pos_r;
  logic [iste_pkg::POS_W-1:0] pos_nxt;
  logic [iste_pkg::POS_W-1:0] pos;
  iste_pkg::fields_t          fields_r;
  field_sel_t                 sel;
  logic                       first;
  logic                       is_digit;
  logic [3:0]                 digit;

  function automatic logic [iste_pkg::YEAR_W-1:0] push_year(
    logic [iste_pkg::YEAR_W-1:0] f, logic [3:0] d, logic first_dig);
    logic [iste_pkg::YEAR_W+3:0] t;
    t = ({4'b0, f} << 3) + ({4'b0, f} << 1) + {{iste_pkg::YEAR_W{1'b0}}, d};
    return first_dig ? {{(iste_pkg::YEAR_W-4){1'b0}}, d} : t[iste_pkg::YEAR_W-1:0];
  endfunction

  function automatic logic [iste_pkg::FLD_W-1:0] push_fld(
    logic [iste_pkg::FLD_W-1:0] f, logic [3:0] d, logic first_dig);
    logic [iste_pkg::FLD_W+3:0] t;
    t = ({4'b0, f} << 3) + ({4'b0, f} << 1) + {{iste_pkg::FLD_W{1'b0}}, d};
    return first_dig ? {{(iste_pkg::FLD_W-4){1'b0}}, d} : t[iste_pkg::FLD_W-1:0];
  endfunction

  always_comb begin
    pos      = start_req ? '0 : pos_r;
    is_digit = (ch >= iste_pkg::CHAR_ZERO) && (ch <= iste_pkg::CHAR_NINE);
    digit    = is_digit ? ch[3:0] : 4'd0;

    // Map position to field; the first digit of a field replaces it
    sel   = FLD_NONE;
    first = 1'b0;
    if (pos <= iste_pkg::POS_YEAR_END) begin
      sel   = FLD_YEAR;
      first = (pos == iste_pkg::POS_YEAR);
    end else if (pos == iste_pkg::POS_MONTH || pos == iste_pkg::POS_MONTH + 5'd1) begin
      sel   = FLD_MONTH;
      first = (pos == iste_pkg::POS_MONTH);
    end else if (pos == iste_pkg::POS_DAY || pos == iste_pkg::POS_DAY + 5'd1) begin
      sel   = FLD_DAY;
      first = (pos == iste_pkg::POS_DAY);
    end else if (pos == iste_pkg::POS_HOUR || pos == iste_pkg::POS_HOUR + 5'd1) begin
      sel   = FLD_HOUR;
      first = (pos == iste_pkg::POS_HOUR);
    end else if (pos == iste_pkg::POS_MINUTE || pos == iste_pkg::POS_MINUTE + 5'd1) begin
      sel   = FLD_MINUTE;
      first = (pos == iste_pkg::POS_MINUTE);
    end else if (pos == iste_pkg::POS_SECOND || pos == iste_pkg::POS_SECOND + 5'd1) begin
      sel   = FLD_SECOND;
      first = (pos == iste_pkg::POS_SECOND);
    end else if (pos == iste_pkg::POS_SIGN) begin
      sel   = FLD_SIGN;
    end else if (pos == iste_pkg::POS_ZHOUR || pos == iste_pkg::POS_ZHOUR + 5'd1) begin
      sel   = FLD_ZHOUR;
      first = (pos == iste_pkg::POS_ZHOUR);
    end else if (pos == iste_pkg::POS_ZMIN || pos == iste_pkg::LAST_POS) begin
      sel   = FLD_ZMIN;
      first = (pos == iste_pkg::POS_ZMIN);
    end

    fields_nxt = fields_r;
    if (pos == '0) begin
      fields_nxt.err = 1'b0;
    end
    if (sel != FLD_NONE && sel != FLD_SIGN && !is_digit) begin
      fields_nxt.err = 1'b1;
    end

    case (sel)
      FLD_YEAR:   fields_nxt.year   = push_year(fields_r.year, digit, first);
      FLD_MONTH:  fields_nxt.month  = push_fld(fields_r.month, digit, first);
      FLD_DAY:    fields_nxt.day    = push_fld(fields_r.day, digit, first);
      FLD_HOUR:   fields_nxt.hour   = push_fld(fields_r.hour, digit, first);
      FLD_MINUTE: fields_nxt.minute = push_fld(fields_r.minute, digit, first);
      FLD_SECOND: fields_nxt.second = push_fld(fields_r.second, digit, first);
      FLD_SIGN:   fields_nxt.zone_neg = (ch == iste_pkg::CHAR_MINUS);
      FLD_ZHOUR:  fields_nxt.zone_hours = push_fld(fields_r.zone_hours, digit, first);
      FLD_ZMIN:   fields_nxt.zone_minutes = push_fld(fields_r.zone_minutes, digit, first);
      default:    ;
    endcase

    // Wrap to the start after the last character
    pos_nxt = (pos == iste_pkg::LAST_POS) ? '0 : pos + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fields_r <= '0;
    end else if (xfer) begin
      pos_r    <= pos_nxt;
      fields_r <= fields_nxt;
    end
  end

  assign pos_o = pos_r;

endmodule

`default_nettype wire

@@ hdl/iste_calc.sv @@
// Four-stage epoch arithmetic: year seconds, leap days, day seconds, final sum.
// Depends on iste_pkg (fields_t, calendar constants, month table).
`default_nettype none

module iste_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               launch,
  input  iste_pkg::fields_t  fields,
  output logic [3:0]         stage_valid,
  output logic               res_valid,
  output logic [31:0]        res_epoch,
  output logic               res_err
);

  // Stage 1: captured fields
  logic              v1_r;
  iste_pkg::fields_t f1_r;

  // Stage 1 -> 2
  logic [iste_pkg::YEAR_W-1:0]   ym1;
  logic [iste_pkg::YEAR_W+12:0]  prod_y;
  logic [iste_pkg::YEAR_W+12:0]  prod_l;
  logic [31:0]                   ysecs_nxt;
  logic [19:0]                   hms;
  logic [19:0]                   zone_mag;
  logic [31:0]                   hz_nxt;
  logic                          month_ok;

  logic                          v2_r;
  logic [iste_pkg::YEAR_W-1:0]   y2_r;
  logic [iste_pkg::Q_W-1:0]      qy2_r;
  logic [iste_pkg::Q_W-1:0]      ql2_r;
  logic [31:0]                   ysecs2_r;
  logic [31:0]                   hz2_r;
  logic                          month_ok2_r;
  logic                          month_gt2_2_r;
  logic [8:0]                    dbm2_r;
  logic [iste_pkg::FLD_W-1:0]    day2_r;
  logic                          err2_r;

  // Stage 2 -> 3
  logic [iste_pkg::YEAR_W-1:0]   ym1_2;
  logic [iste_pkg::YEAR_W-1:0]   cent_y;
  logic                          leap_y;
  logic [iste_pkg::DAYS_W-1:0]   leap_days;
  logic [iste_pkg::DAYS_W-1:0]   month_days;
  logic [iste_pkg::DAYS_W-1:0]   days_nxt;

  logic                          v3_r;
  logic [iste_pkg::DAYS_W-1:0]   days3_r;
  logic [31:0]                   rest3_r;
  logic                          err3_r;

  // Stage 3 -> 4
  logic [31:0]                   day_secs_nxt;

  logic                          v4_r;
  logic [31:0]                   day_secs4_r;
  logic [31:0]                   rest4_r;
  logic                          err4_r;

  always_comb begin
    ym1       = f1_r.year - 14'd1;
    prod_y    = {13'b0, f1_r.year} * {14'b0, iste_pkg::DIV100_MUL};
    prod_l    = {13'b0, ym1} * {14'b0, iste_pkg::DIV100_MUL};
    ysecs_nxt = ({18'b0, f1_r.year} - {18'b0, iste_pkg::EPOCH_YEAR})
                * iste_pkg::SECS_PER_YEAR;
    hms       = 20'(f1_r.hour) * iste_pkg::SECS_PER_HOUR
              + 20'(f1_r.minute) * iste_pkg::SECS_PER_MIN
              + 20'(f1_r.second);
    zone_mag  = 20'(f1_r.zone_hours) * iste_pkg::SECS_PER_HOUR
              + 20'(f1_r.zone_minutes) * iste_pkg::SECS_PER_MIN;
    // A negative zone counts only with a nonzero zone hour
    if (f1_r.zone_neg && f1_r.zone_hours != '0) begin
      hz_nxt = 32'(hms) - 32'(zone_mag);
    end else begin
      hz_nxt = 32'(hms) + 32'(zone_mag);
    end
    month_ok = (f1_r.month >= 7'd1) && (f1_r.month <= 7'd12);
  end

  always_comb begin
    ym1_2  = y2_r - 14'd1;
    cent_y = 14'({6'b0, qy2_r} * iste_pkg::CENTURY);
    leap_y = (y2_r[1:0] == 2'b00) && ((y2_r != cent_y) || (qy2_r[1:0] == 2'b00));

    // Leap years from 1972 up to the year before this one
    if (y2_r <= iste_pkg::LEAP_BASE_YEAR) begin
      leap_days = '0;
    end else begin
      leap_days = {1'b0, ym1_2[iste_pkg::YEAR_W-1:2]} - iste_pkg::LEAP_Q4_BASE
                - {5'b0, ql2_r} + iste_pkg::LEAP_Q100_BASE
                + {7'b0, ql2_r[iste_pkg::Q_W-1:2]} - iste_pkg::LEAP_Q400_BASE;
    end

    if (month_ok2_r) begin
      month_days = {4'b0, dbm2_r} + {12'b0, month_gt2_2_r && leap_y};
    end else begin
      month_days = '0;
    end

    // day - 1 may go to -1; the count stays a signed 13-bit value
    days_nxt = leap_days + month_days + {6'b0, day2_r} - 13'd1;
  end

  assign day_secs_nxt = {{(32-iste_pkg::DAYS_W){days3_r[iste_pkg::DAYS_W-1]}}, days3_r}
                        * iste_pkg::SECS_PER_DAY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= launch;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      f1_r <= fields;
    end
    y2_r          <= f1_r.year;
    qy2_r         <= prod_y[iste_pkg::DIV100_SHIFT +: iste_pkg::Q_W];
    ql2_r         <= prod_l[iste_pkg::DIV100_SHIFT +: iste_pkg::Q_W];
    ysecs2_r      <= ysecs_nxt;
    hz2_r         <= hz_nxt;
    month_ok2_r   <= month_ok;
    month_gt2_2_r <= (f1_r.month > 7'd2);
    dbm2_r        <= iste_pkg::days_before_month(f1_r.month[3:0]);
    day2_r        <= f1_r.day;
    err2_r        <= f1_r.err | ~month_ok;

    days3_r <= days_nxt;
    rest3_r <= ysecs2_r + hz2_r;
    err3_r  <= err2_r;

    day_secs4_r <= day_secs_nxt;
    rest4_r     <= rest3_r;
    err4_r      <= err3_r;
  end

  assign stage_valid = {v4_r, v3_r, v2_r, v1_r};
  assign res_valid   = v4_r;
  assign res_epoch   = day_secs4_r + rest4_r;
  assign res_err     = err4_r;

endmodule

`default_nettype wire

@@ dv/tb_iso_timestamp_to_epoch.sv @@
`timescale 1ns / 1ps
// Testbench for iso_timestamp_to_epoch: sends timestamp text one character per transfer and
// checks every epoch result against a predictor of the parser and calendar arithmetic.
// Depends on iste_pkg and the iso_timestamp_to_epoch RTL.
module tb_iso_timestamp_to_epoch;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned RANDOM_CHARS = 1500;
  localparam int unsigned QUIET_CHARS  = 250;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  localparam logic [31:0] YEAR_ORIGIN  = 32'd1970;
  localparam logic [31:0] FIRST_LEAP   = 32'd1972;
  localparam logic [31:0] SECS_IN_YEAR = 32'd31536000;
  localparam logic [31:0] SECS_IN_DAY  = 32'd86400;
  localparam logic [31:0] SECS_IN_HOUR = 32'd3600;
  localparam logic [31:0] SECS_IN_MIN  = 32'd60;
  // Days before the first of each month, January at index 0
  localparam logic [11:0][8:0] MONTH_START_DAY = {
    9'd334, 9'd304, 9'd273, 9'd243, 9'd212, 9'd181,
    9'd151, 9'd120, 9'd90,  9'd59,  9'd31,  9'd0
  };

  typedef struct packed {
    logic [31:0] seconds;
    logic        format_error;
  } epoch_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_ch;
  logic               in_start_req;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_epoch_seconds;
  logic               out_format_error;

  iso_timestamp_to_epoch dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_ch             (in_ch),
    .in_start_req      (in_start_req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_epoch_seconds (out_epoch_seconds),
    .out_format_error  (out_format_error)
  );

  // Parser state as the predictor sees it
  logic [iste_pkg::POS_W-1:0]  next_pos     = '0;
  logic [iste_pkg::YEAR_W-1:0] year_acc     = '0;
  logic [iste_pkg::FLD_W-1:0]  month_acc    = '0;
  logic [iste_pkg::FLD_W-1:0]  day_acc      = '0;
  logic [iste_pkg::FLD_W-1:0]  hour_acc     = '0;
  logic [iste_pkg::FLD_W-1:0]  minute_acc   = '0;
  logic [iste_pkg::FLD_W-1:0]  second_acc   = '0;
  logic                        zone_neg     = 1'b0;
  logic [iste_pkg::FLD_W-1:0]  zone_hr_acc  = '0;
  logic [iste_pkg::FLD_W-1:0]  zone_min_acc = '0;
  logic                        bad_format   = 1'b0;

  epoch_result_t expected_epochs[$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count;
  bit            idle_on;
  bit            hold_request;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic logic [iste_pkg::YEAR_W-1:0] shift_digit(
    logic [iste_pkg::YEAR_W-1:0] acc, logic [3:0] d, logic first);
    return first ? iste_pkg::YEAR_W'(d)
                 : iste_pkg::YEAR_W'(acc * 14'd10 + iste_pkg::YEAR_W'(d));
  endfunction

  function automatic logic leap_year(logic [31:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Leap years from 1972 on, strictly below y
  function automatic logic [31:0] leap_days_below(logic [31:0] y);
    logic [31:0] prev;
    if (y <= FIRST_LEAP) return 32'd0;
    prev = y - 1;
    return (prev / 4 - 32'd492) - (prev / 100 - 32'd19) + (prev / 400 - 32'd4);
  endfunction

  function automatic epoch_result_t predict_epoch();
    logic [31:0]   y;
    logic [31:0]   m;
    logic [31:0]   days;
    logic [31:0]   secs;
    logic [31:0]   zone;
    logic          month_ok;
    epoch_result_t r;
    y = 32'(year_acc);
    m = 32'(month_acc);
    month_ok = (m >= 1) && (m <= 12);
    secs = (y - YEAR_ORIGIN) * SECS_IN_YEAR;
    days = leap_days_below(y);
    if (month_ok) begin
      if (m > 2 && leap_year(y)) days += 1;
      days += 32'(MONTH_START_DAY[m - 1]);
    end
    // day zero wraps below zero on purpose
    days += 32'(day_acc) - 32'd1;
    secs += days * SECS_IN_DAY;
    secs += 32'(hour_acc) * SECS_IN_HOUR + 32'(minute_acc) * SECS_IN_MIN + 32'(second_acc);
    // a minus sign with zero zone hours is dropped
    if (zone_neg && zone_hr_acc != 0)
      zone = 32'd0 - 32'(zone_hr_acc) * SECS_IN_HOUR - 32'(zone_min_acc) * SECS_IN_MIN;
    else
      zone = 32'(zone_hr_acc) * SECS_IN_HOUR + 32'(zone_min_acc) * SECS_IN_MIN;
    r.seconds = secs + zone;
    r.format_error = !month_ok;
    return r;
  endfunction

  task automatic track_char(logic [7:0] c, logic s);
    logic [iste_pkg::POS_W-1:0] pos;
    logic                       is_dig;
    logic                       sep;
    logic [3:0]                 d;
    epoch_result_t              r;
    if (s) next_pos = '0;
    pos = next_pos;
    if (pos == iste_pkg::POS_YEAR) bad_format = 1'b0;
    is_dig = (c >= iste_pkg::CHAR_ZERO) && (c <= iste_pkg::CHAR_NINE);
    d = is_dig ? 4'(c - iste_pkg::CHAR_ZERO) : 4'd0;
    sep = (pos == iste_pkg::POS_MONTH - 1) || (pos == iste_pkg::POS_DAY - 1) ||
          (pos == iste_pkg::POS_HOUR - 1) || (pos == iste_pkg::POS_MINUTE - 1) ||
          (pos == iste_pkg::POS_SECOND - 1) || (pos == iste_pkg::POS_SIGN) ||
          (pos == iste_pkg::POS_ZMIN - 1) || (pos > iste_pkg::LAST_POS);
    if (!sep && !is_dig) bad_format = 1'b1;

    if (pos <= iste_pkg::POS_YEAR_END)
      year_acc = shift_digit(year_acc, d, pos == iste_pkg::POS_YEAR);
    else if (pos == iste_pkg::POS_MONTH || pos == iste_pkg::POS_MONTH + 1)
      month_acc = iste_pkg::FLD_W'(shift_digit(iste_pkg::YEAR_W'(month_acc), d,
                                               pos == iste_pkg::POS_MONTH));
    else if (pos == iste_pkg::POS_DAY || pos == iste_pkg::POS_DAY + 1)
      day_acc = iste_pkg::FLD_W'(shift_digit(iste_pkg::YEAR_W'(day_acc), d,
                                             pos == iste_pkg::POS_DAY));
    else if (pos == iste_pkg::POS_HOUR || pos == iste_pkg::POS_HOUR + 1)
      hour_acc = iste_pkg::FLD_W'(shift_digit(iste_pkg::YEAR_W'(hour_acc), d,
                                              pos == iste_pkg::POS_HOUR));
    else if (pos == iste_pkg::POS_MINUTE || pos == iste_pkg::POS_MINUTE + 1)
      minute_acc = iste_pkg::FLD_W'(shift_digit(iste_pkg::YEAR_W'(minute_acc), d,
                                                pos == iste_pkg::POS_MINUTE));
    else if (pos == iste_pkg::POS_SECOND || pos == iste_pkg::POS_SECOND + 1)
      second_acc = iste_pkg::FLD_W'(shift_digit(iste_pkg::YEAR_W'(second_acc), d,
                                                pos == iste_pkg::POS_SECOND));
    else if (pos == iste_pkg::POS_SIGN)
      zone_neg = (c == iste_pkg::CHAR_MINUS);
    else if (pos == iste_pkg::POS_ZHOUR || pos == iste_pkg::POS_ZHOUR + 1)
      zone_hr_acc = iste_pkg::FLD_W'(shift_digit(iste_pkg::YEAR_W'(zone_hr_acc), d,
                                                 pos == iste_pkg::POS_ZHOUR));
    else if (pos == iste_pkg::POS_ZMIN || pos == iste_pkg::POS_ZMIN + 1)
      zone_min_acc = iste_pkg::FLD_W'(shift_digit(iste_pkg::YEAR_W'(zone_min_acc), d,
                                                  pos == iste_pkg::POS_ZMIN));

    if (pos >= iste_pkg::LAST_POS) begin
      r = predict_epoch();
      if (r.format_error) bad_format = 1'b1;
      r.format_error = bad_format;
      expected_epochs.push_back(r);
      next_pos = '0;
    end else begin
      next_pos = pos + 1'b1;
    end
  endtask

  task automatic check_result();
    epoch_result_t want;
    if (expected_epochs.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual epoch_seconds=%0d format_error=%0b",
               $time, out_epoch_seconds, out_format_error);
      mismatches++;
    end else begin
      want = expected_epochs.pop_front();
      if (out_epoch_seconds !== want.seconds) begin
        $display("%0t: epoch_seconds mismatch: expected %0d, actual %0d",
                 $time, $signed(want.seconds), out_epoch_seconds);
        mismatches++;
      end
      if (out_format_error !== want.format_error) begin
        $display("%0t: format_error mismatch: expected %0b, actual %0b",
                 $time, want.format_error, out_format_error);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) track_char(in_ch, in_start_req);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        hold_left = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_iso_timestamp_to_epoch: errors");
    $finish;
  end

  // Hold valid and payload until the transfer; an idle burst may come first
  task automatic send_char(logic [7:0] c, logic s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_ch        <= c;
    in_start_req <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send the first count characters of text, one of them optionally replaced
  task automatic send_text(string text, logic first_start, int bad_pos, logic [7:0] bad_val,
                           int count);
    logic [7:0] c;
    for (int i = 0; i < count; i++) begin
      c = (i == bad_pos) ? bad_val : 8'(text[i]);
      send_char(c, (i == 0) ? first_start : 1'b0);
    end
  endtask

  function automatic int unsigned field_value(int unsigned typical_max);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, typical_max);
  endfunction

  function automatic string random_stamp();
    int unsigned y;
    case ($urandom_range(0, 7))
      0:       y = $urandom_range(0, 9999);
      1:       y = $urandom_range(1960, 1975);
      default: y = $urandom_range(1970, 2500);
    endcase
    return $sformatf("%04d-%02d-%02dT%02d:%02d:%02d%s%02d:%02d", y,
                     field_value(12), field_value(31), field_value(23), field_value(59),
                     field_value(59), ($urandom_range(0, 1) != 0) ? "-" : "+",
                     field_value(14), field_value(59));
  endfunction

  task automatic test_epoch_origin();
    send_text("1970-01-01T00:00:00+00:00", 1'b1, -1, 8'h00, 25);
    // all zeros: bad month, day zero and a year far before the origin
    send_text("0000-00-00T00:00:00+00:00", 1'b1, -1, 8'h00, 25);
  endtask

  task automatic test_field_extremes();
    send_text("9999-12-31T99:99:99-99:99", 1'b1, -1, 8'h00, 25);
    send_text("2000-02-29T23:59:59-00:30", 1'b1, -1, 8'h00, 25);
    send_text("2100-03-01T12:00:00+14:00", 1'b1, -1, 8'h00, 25);
    send_text("1969-12-31T23:59:59-01:00", 1'b1, -1, 8'h00, 25);
  endtask

  task automatic test_format_errors();
    send_text("2024-07-15T08:30:00+05:30", 1'b1, 6, 8'hFF, 25);
    send_text("2024-07-15T08:30:00+05:30", 1'b1, 0, 8'h00, 25);
    send_text("2024-07-15T08:30:00+05:30", 1'b1, 24, 8'h2F, 25);
    send_text("2024-07-15T08:30:00+05:30", 1'b1, 12, 8'h3A, 25);
    send_text("2024-13-15T08:30:00+05:30", 1'b1, -1, 8'h00, 25);
    // separators are free; an odd sign counts as plus
    send_text("2024x03y05Z12;34;56*05!30", 1'b1, -1, 8'h00, 25);
  endtask

  task automatic test_restart();
    send_text("1999-11-22T01:02:03+04:05", 1'b1, -1, 8'h00, 10);
    send_text("2038-01-19T03:14:07+00:00", 1'b1, -1, 8'h00, 25);
    // next stamp follows without a start flag
    send_text("2106-02-07T06:28:16-11:45", 1'b0, -1, 8'h00, 25);
  endtask

  task automatic test_output_stall();
    hold_request = 1'b1;
    repeat (3) send_text(random_stamp(), 1'b0, -1, 8'h00, 25);
  endtask

  task automatic test_random_stream();
    int unsigned sent;
    int unsigned k;
    int unsigned kind;
    logic        need_start;
    int          bad_pos;
    logic [7:0]  bad_val;
    string       s;
    sent = 0;
    need_start = 1'b1;
    while (sent < RANDOM_CHARS) begin
      idle_on = (sent < RANDOM_CHARS - QUIET_CHARS);
      kind = $urandom_range(0, 9);
      s = random_stamp();
      bad_pos = -1;
      bad_val = 8'h00;
      if ($urandom_range(0, 7) == 0) begin
        bad_pos = $urandom_range(0, 24);
        bad_val = 8'($urandom_range(0, 255));
      end
      if (kind <= 7) begin
        send_text(s, need_start | 1'($urandom_range(0, 1)), bad_pos, bad_val, 25);
        sent += 25;
        need_start = 1'b0;
      end else if (kind == 8) begin
        // broken stamp, dropped by the next start
        k = $urandom_range(1, 24);
        send_text(s, need_start | 1'($urandom_range(0, 1)), bad_pos, bad_val, k);
        sent += k;
        need_start = 1'b1;
      end else begin
        k = $urandom_range(1, 30);
        repeat (k) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        sent += k;
        need_start = 1'b1;
      end
    end
  endtask

  initial begin
    idle_on      = 1'b1;
    hold_request = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_ch        <= 8'h00;
    in_start_req <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_epoch_origin();
    test_field_extremes();
    test_format_errors();
    test_restart();
    test_output_stall();
    test_random_stream();

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_epochs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_iso_timestamp_to_epoch: clean");
    else
      $display("tb_iso_timestamp_to_epoch: errors");
    $finish;
  end

endmodule
